[hdl/uv_sphere_vertex_generator_macros.svh]
// Assertion macros for the UV sphere vertex generator
`ifndef UV_SPHERE_VERTEX_GENERATOR_MACROS_SVH
`define UV_SPHERE_VERTEX_GENERATOR_MACROS_SVH
`ifndef SYNTH
`define UVS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("uvs check failed");
`define UVS_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("uvs check failed");
`else
`define UVS_ASSERT_IMP(label, ante, cons)
`define UVS_ASSERT_NXT(label, ante, cons)
`endif
`endif

[hdl/uvs_pkg.sv]
`default_nettype none
package uvs_pkg;

   localparam int MaxDivisions = 256;
   localparam int DivSteps     = 17;
   localparam int CordicSteps  = 24;
   localparam int StPhase      = DivSteps + 1;
   localparam int StCordic     = StPhase + 1;
   localparam int StFold       = StCordic + CordicSteps;
   localparam int StMul1       = StFold + 1;
   localparam int StMul2       = StMul1 + 1;
   localparam int StLast       = StMul2 + 1;

   localparam logic signed [33:0] CordicGain = 34'sd652032874;

   typedef enum logic [1:0] {
      CSR_RADIUS  = 2'd0,
      CSR_SECTORS = 2'd1,
      CSR_STACKS  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic               ok;
      logic               up;
      logic               lo;
      logic [16:0]        corner;
      logic [25:0]        rem_a;
      logic [25:0]        rem_b;
      logic [25:0]        rem_c;
      logic [16:0]        q_a;
      logic [16:0]        q_b;
      logic [16:0]        q_c;
      logic [1:0]         quad_u;
      logic [1:0]         quad_v;
      logic signed [33:0] xu;
      logic signed [33:0] yu;
      logic signed [32:0] zu;
      logic signed [33:0] xv;
      logic signed [33:0] yv;
      logic signed [32:0] zv;
      logic signed [15:0] cu;
      logic signed [15:0] su;
      logic signed [15:0] cv;
      logic signed [15:0] sv;
      logic signed [31:0] pcc;
      logic signed [31:0] pcs;
      logic signed [32:0] prs;
      logic signed [48:0] rcc;
      logic signed [48:0] rcs;
   } stage_type;

   function automatic logic [31:0] atan_of(input logic [4:0] k);
      logic [31:0] a;
      unique case (k)
         5'd0:  a = 32'd536870912;
         5'd1:  a = 32'd316933406;
         5'd2:  a = 32'd167458907;
         5'd3:  a = 32'd85004756;
         5'd4:  a = 32'd42667331;
         5'd5:  a = 32'd21354465;
         5'd6:  a = 32'd10679838;
         5'd7:  a = 32'd5340245;
         5'd8:  a = 32'd2670163;
         5'd9:  a = 32'd1335087;
         5'd10: a = 32'd667544;
         5'd11: a = 32'd333772;
         5'd12: a = 32'd166886;
         5'd13: a = 32'd83443;
         5'd14: a = 32'd41722;
         5'd15: a = 32'd20861;
         5'd16: a = 32'd10430;
         5'd17: a = 32'd5215;
         5'd18: a = 32'd2608;
         5'd19: a = 32'd1304;
         5'd20: a = 32'd652;
         5'd21: a = 32'd326;
         5'd22: a = 32'd163;
         5'd23: a = 32'd81;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

   // Q2.30 -> Q1.14, round half up, clamp to +-1.0
   function automatic logic signed [15:0] to_q14(input logic signed [34:0] v);
      logic signed [34:0] r;
      logic signed [15:0] q;
      r = (v + 35'sd32768) >>> 16;
      if (r > 35'sd16384) begin
         q = 16'sd16384;
      end else if (r < -35'sd16384) begin
         q = -16'sd16384;
      end else begin
         q = r[15:0];
      end
      return q;
   endfunction

   function automatic logic [8:0] clamp_div(input logic [8:0] v, input logic [8:0] lo);
      logic [8:0] r;
      if (v < lo) begin
         r = lo;
      end else if (v > 9'(MaxDivisions)) begin
         r = 9'(MaxDivisions);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[hdl/uv_sphere_vertex_generator.sv]
// Throughput: one word per cycle while the pipeline is not held; a 17-stage
// restoring divider, a 24-stage CORDIC pair and a two-stage multiplier chain
// are all fully pipelined.
// The whole pipeline holds while a response waits and rsp_tready is low.
// Synchronous active-high reset: pipeline empty, radius 1.0, 32 sectors, 32 stacks.
`default_nettype none
`include "uv_sphere_vertex_generator_macros.svh"
module uv_sphere_vertex_generator
   import uvs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [23:0]  req_tdata,   // stack_index, sector_index
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_s, tex_t, corner_index,
   // upper_tri_valid, lower_tri_valid, point_valid
   output logic [159:0]      rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_wdata
);

   logic [15:0] radius_ff;
   logic [8:0]  sectors_ff;
   logic [8:0]  stacks_ff;
   logic [8:0]  sec;
   logic [8:0]  stk;

   stage_type   st_ff [0:StLast];
   stage_type   st_in [0:StLast];
   logic [StLast:0] vld_ff;
   logic        advance;

   logic [8:0]  i_idx;
   logic [8:0]  j_idx;

   // final fields
   logic signed [48:0] px_r;
   logic signed [48:0] py_r;
   logic signed [32:0] pz_r;
   logic signed [31:0] nx_r;
   logic signed [31:0] ny_r;
   stage_type   fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= 16'd256;
         sectors_ff <= 9'd32;
         stacks_ff  <= 9'd32;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RADIUS:  radius_ff  <= csr_wdata;
            CSR_SECTORS: sectors_ff <= csr_wdata[8:0];
            CSR_STACKS:  stacks_ff  <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   assign sec     = clamp_div(sectors_ff, 9'd3);
   assign stk     = clamp_div(stacks_ff, 9'd2);
   assign i_idx   = req_tdata[8:0];
   assign j_idx   = req_tdata[17:9];
   assign advance = !vld_ff[StLast] || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      logic [25:0]        dsh;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [32:0] at;
      logic [15:0]        ph_u;
      logic [15:0]        ph_v;
      logic signed [34:0] c0;
      logic signed [34:0] s0;
      logic               grid_cell;

      st_in[0]        = st_ff[0];
      grid_cell       = (i_idx < stk) && (j_idx < sec);
      st_in[0].ok     = (i_idx <= stk) && (j_idx <= sec);
      st_in[0].up     = grid_cell && (i_idx != 9'd0);
      st_in[0].lo     = grid_cell && (i_idx != stk - 9'd1);
      st_in[0].corner = 17'(19'(i_idx) * (19'(sec) + 19'd1) + 19'(j_idx));
      st_in[0].rem_a  = {1'b0, j_idx, 16'd0} + 26'(sec[8:1]);
      st_in[0].rem_b  = {2'b0, i_idx, 15'd0} + 26'(stk[8:1]);
      st_in[0].rem_c  = {1'b0, i_idx, 16'd0} + 26'(stk[8:1]);
      st_in[0].q_a    = '0;
      st_in[0].q_b    = '0;
      st_in[0].q_c    = '0;

      for (int n = 1; n <= StLast; n++) begin
         st_in[n] = st_ff[n-1];
         dsh  = '0;
         dx   = '0;
         dy   = '0;
         at   = '0;
         ph_u = '0;
         ph_v = '0;
         c0   = '0;
         s0   = '0;
         if (n <= DivSteps) begin
            dsh = 26'(sec) << (DivSteps - n);
            if (st_ff[n-1].rem_a >= dsh) begin
               st_in[n].rem_a = st_ff[n-1].rem_a - dsh;
               st_in[n].q_a[DivSteps - n] = 1'b1;
            end
            dsh = 26'(stk) << (DivSteps - n);
            if (st_ff[n-1].rem_b >= dsh) begin
               st_in[n].rem_b = st_ff[n-1].rem_b - dsh;
               st_in[n].q_b[DivSteps - n] = 1'b1;
            end
            if (st_ff[n-1].rem_c >= dsh) begin
               st_in[n].rem_c = st_ff[n-1].rem_c - dsh;
               st_in[n].q_c[DivSteps - n] = 1'b1;
            end
         end else if (n == StPhase) begin
            ph_v = st_ff[n-1].q_a[15:0];
            ph_u = 16'd16384 - st_ff[n-1].q_b[15:0];
            st_in[n].quad_u = ph_u[15:14];
            st_in[n].quad_v = ph_v[15:14];
            st_in[n].zu = $signed({3'b000, ph_u[13:0], 16'd0});
            st_in[n].zv = $signed({3'b000, ph_v[13:0], 16'd0});
            st_in[n].xu = CordicGain;
            st_in[n].yu = '0;
            st_in[n].xv = CordicGain;
            st_in[n].yv = '0;
         end else if (n < StFold) begin
            at = $signed({1'b0, atan_of(5'(n - StCordic))});
            dx = st_ff[n-1].yu >>> (n - StCordic);
            dy = st_ff[n-1].xu >>> (n - StCordic);
            if (st_ff[n-1].zu >= 0) begin
               st_in[n].xu = st_ff[n-1].xu - dx;
               st_in[n].yu = st_ff[n-1].yu + dy;
               st_in[n].zu = st_ff[n-1].zu - at;
            end else begin
               st_in[n].xu = st_ff[n-1].xu + dx;
               st_in[n].yu = st_ff[n-1].yu - dy;
               st_in[n].zu = st_ff[n-1].zu + at;
            end
            dx = st_ff[n-1].yv >>> (n - StCordic);
            dy = st_ff[n-1].xv >>> (n - StCordic);
            if (st_ff[n-1].zv >= 0) begin
               st_in[n].xv = st_ff[n-1].xv - dx;
               st_in[n].yv = st_ff[n-1].yv + dy;
               st_in[n].zv = st_ff[n-1].zv - at;
            end else begin
               st_in[n].xv = st_ff[n-1].xv + dx;
               st_in[n].yv = st_ff[n-1].yv - dy;
               st_in[n].zv = st_ff[n-1].zv + at;
            end
         end else if (n == StFold) begin
            unique case (st_ff[n-1].quad_u)
               2'd0: begin c0 = 35'(st_ff[n-1].xu);  s0 = 35'(st_ff[n-1].yu);  end
               2'd1: begin c0 = -35'(st_ff[n-1].yu); s0 = 35'(st_ff[n-1].xu);  end
               2'd2: begin c0 = -35'(st_ff[n-1].xu); s0 = -35'(st_ff[n-1].yu); end
               default: begin c0 = 35'(st_ff[n-1].yu); s0 = -35'(st_ff[n-1].xu); end
            endcase
            st_in[n].cu = to_q14(c0);
            st_in[n].su = to_q14(s0);
            unique case (st_ff[n-1].quad_v)
               2'd0: begin c0 = 35'(st_ff[n-1].xv);  s0 = 35'(st_ff[n-1].yv);  end
               2'd1: begin c0 = -35'(st_ff[n-1].yv); s0 = 35'(st_ff[n-1].xv);  end
               2'd2: begin c0 = -35'(st_ff[n-1].xv); s0 = -35'(st_ff[n-1].yv); end
               default: begin c0 = 35'(st_ff[n-1].yv); s0 = -35'(st_ff[n-1].xv); end
            endcase
            st_in[n].cv = to_q14(c0);
            st_in[n].sv = to_q14(s0);
         end else if (n == StMul1) begin
            st_in[n].pcc = 32'(st_ff[n-1].cu) * 32'(st_ff[n-1].cv);
            st_in[n].pcs = 32'(st_ff[n-1].cu) * 32'(st_ff[n-1].sv);
            st_in[n].prs = 33'($signed({1'b0, radius_ff})) * 33'(st_ff[n-1].su);
         end else if (n == StMul2) begin
            st_in[n].rcc = $signed({33'd0, radius_ff}) * 49'(st_ff[n-1].pcc);
            st_in[n].rcs = $signed({33'd0, radius_ff}) * 49'(st_ff[n-1].pcs);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[StLast-1:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int n = 0; n <= StLast; n++) begin
            st_ff[n] <= st_in[n];
         end
      end
   end

   assign fin  = st_ff[StLast];
   assign px_r = (fin.rcc + 49'sd134217728) >>> 28;
   assign py_r = (fin.rcs + 49'sd134217728) >>> 28;
   assign pz_r = (fin.prs + 33'sd8192) >>> 14;
   assign nx_r = (fin.pcc + 32'sd8192) >>> 14;
   assign ny_r = (fin.pcs + 32'sd8192) >>> 14;

   assign rsp_tvalid = vld_ff[StLast];
   always_comb begin
      rsp_tdata = '0;
      if (fin.ok) begin
         rsp_tdata[16:0]    = px_r[16:0];
         rsp_tdata[33:17]   = py_r[16:0];
         rsp_tdata[50:34]   = pz_r[16:0];
         rsp_tdata[66:51]   = nx_r[15:0];
         rsp_tdata[82:67]   = ny_r[15:0];
         rsp_tdata[98:83]   = fin.su;
         rsp_tdata[115:99]  = fin.q_a;
         rsp_tdata[132:116] = fin.q_c;
         rsp_tdata[149:133] = fin.corner;
         rsp_tdata[150]     = fin.up;
         rsp_tdata[151]     = fin.lo;
         rsp_tdata[152]     = 1'b1;
      end
   end

   `UVS_ASSERT_IMP(a_off_grid_zero, rsp_tvalid && !rsp_tdata[152], rsp_tdata[151:0] == '0)
   `UVS_ASSERT_IMP(a_tri_on_grid, rsp_tvalid && (rsp_tdata[150] || rsp_tdata[151]), rsp_tdata[152])
   `UVS_ASSERT_IMP(a_norm_z_unit, rsp_tvalid, $signed(rsp_tdata[98:83]) <= 16'sd16384 && $signed(rsp_tdata[98:83]) >= -16'sd16384)
   `UVS_ASSERT_NXT(a_entry, req_tvalid && req_tready, vld_ff[0])

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
   import uvs_pkg::*;

   localparam int CycleLimit  = 400000;
   localparam int PipeLatency = 47;
   localparam csr_index_type CSR_UNUSED = csr_index_type'(2'd3);

   localparam longint AtanTurn[24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};

   typedef struct packed {
      logic [6:0]         pad;
      logic               point_ok;
      logic               lower_tri;
      logic               upper_tri;
      logic [16:0]        corner;
      logic [16:0]        tex_t;
      logic [16:0]        tex_s;
      logic signed [15:0] norm_z;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_x;
      logic signed [16:0] pos_z;
      logic signed [16:0] pos_y;
      logic signed [16:0] pos_x;
   } vertex_word_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [23:0]  req_tdata = '0;   // stack_index, sector_index
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_s, tex_t, corner_index,
   // upper_tri_valid, lower_tri_valid, point_valid
   logic [159:0] rsp_tdata;
   logic         csr_we = 1'b0;
   csr_index_type csr_index = CSR_RADIUS;
   logic [15:0]  csr_wdata = '0;

   vertex_word_type expected_vertices[$];
   int unsigned radius_q88 = 256;
   int unsigned sectors_raw = 32;
   int unsigned stacks_raw = 32;
   int mismatches = 0;
   int cycles = 0;
   bit steady = 1'b0;

   uv_sphere_vertex_generator i_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_we, .csr_index, .csr_wdata
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 28);
   end

   function automatic longint round_sh(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint q14_clamp(longint v);
      longint r;
      r = round_sh(v, 16);
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r;
   endfunction

   function automatic void rotate_turn(input logic [31:0] a, output longint c,
                                       output longint s);
      longint x, y, z, dx, dy;
      x = 652032874;
      y = 0;
      z = longint'(a[29:0]);
      for (int k = 0; k < 24; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (z >= 0) begin
            x -= dx; y += dy; z -= AtanTurn[k];
         end else begin
            x += dx; y -= dy; z += AtanTurn[k];
         end
      end
      case (a[31:30])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
      c = q14_clamp(c);
      s = q14_clamp(s);
   endfunction

   function automatic int unsigned div_clamp(int unsigned v, int unsigned lo);
      if (v < lo) return lo;
      if (v > MaxDivisions) return MaxDivisions;
      return v;
   endfunction

   function automatic vertex_word_type sphere_vertex(int unsigned i, int unsigned j);
      vertex_word_type w;
      int unsigned sec, stk;
      longint unsigned sec_ph, stk_ph;
      longint cu, su, cv, sv, r;
      w = '0;
      sec = div_clamp(sectors_raw, 3);
      stk = div_clamp(stacks_raw, 2);
      r = radius_q88;
      if (i > stk || j > sec) return w;
      sec_ph = (longint'(j) * 65536 + sec / 2) / sec;
      stk_ph = 16384 - (longint'(i) * 32768 + stk / 2) / stk;
      rotate_turn({stk_ph[15:0], 16'h0}, cu, su);
      rotate_turn({sec_ph[15:0], 16'h0}, cv, sv);
      w.pos_x = 17'(round_sh(r * cu * cv, 28));
      w.pos_y = 17'(round_sh(r * cu * sv, 28));
      w.pos_z = 17'(round_sh(r * su, 14));
      w.norm_x = 16'(round_sh(cu * cv, 14));
      w.norm_y = 16'(round_sh(cu * sv, 14));
      w.norm_z = 16'(su);
      w.tex_s = 17'((longint'(j) * 65536 + sec / 2) / sec);
      w.tex_t = 17'((longint'(i) * 65536 + stk / 2) / stk);
      w.corner = 17'(i * (sec + 1) + j);
      if (i < stk && j < sec) begin
         w.upper_tri = (i != 0);
         w.lower_tri = (i != stk - 1);
      end
      w.point_ok = 1'b1;
      return w;
   endfunction

   always @(posedge clock) begin
      vertex_word_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_vertices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", got);
         end else begin
            want = expected_vertices.pop_front();
            if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
                got.pos_z !== want.pos_z || got.norm_x !== want.norm_x ||
                got.norm_y !== want.norm_y || got.norm_z !== want.norm_z ||
                got.tex_s !== want.tex_s || got.tex_t !== want.tex_t ||
                got.corner !== want.corner || got.upper_tri !== want.upper_tri ||
                got.lower_tri !== want.lower_tri || got.point_ok !== want.point_ok)
            begin
               mismatches++;
               if (mismatches <= 10) $display("exp %p\nact %p", want, got);
            end
         end
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_point(int unsigned i, int unsigned j);
      while (!steady && $urandom_range(99) < 28) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, j[8:0], i[8:0]};
      do @(posedge clock); while (!req_tready);
      expected_vertices.insert(expected_vertices.size(), sphere_vertex(i, j));
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_vertices.size() != 0) @(negedge clock);
      repeat (PipeLatency + 5) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int unsigned value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[15:0];
      case (idx)
         CSR_RADIUS:  radius_q88 = value & 16'hFFFF;
         CSR_SECTORS: sectors_raw = value & 9'h1FF;
         CSR_STACKS:  stacks_raw = value & 9'h1FF;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_point(0, 0);
      send_point(16, 8);
      send_point(32, 32);
      send_point(31, 31);
      send_point(33, 0);
      drain();
   endtask

   task automatic test_grid_edges();
      write_reg(CSR_RADIUS, 65535);
      write_reg(CSR_SECTORS, 3);
      write_reg(CSR_STACKS, 2);
      write_reg(CSR_UNUSED, 16'hFFFF);
      send_point(0, 0);
      send_point(1, 2);
      send_point(2, 3);
      send_point(1, 3);
      send_point(2, 0);
      send_point(3, 1);
      send_point(0, 4);
      send_point(511, 511);
      drain();
      write_reg(CSR_RADIUS, 0);
      write_reg(CSR_SECTORS, 16'hFFFF);   // 511, clamps to 256
      write_reg(CSR_STACKS, 256);
      send_point(0, 0);
      send_point(128, 64);
      send_point(255, 255);
      send_point(256, 256);
      send_point(257, 0);
      drain();
      write_reg(CSR_RADIUS, 1);
      write_reg(CSR_SECTORS, 0);          // clamps to 3
      write_reg(CSR_STACKS, 1);           // clamps to 2
      send_point(1, 1);
      send_point(2, 3);
      drain();
      write_reg(CSR_SECTORS, 2);
      write_reg(CSR_STACKS, 300);
      send_point(256, 2);
      send_point(170, 1);
      drain();
   endtask

   task automatic test_random(int count);
      int unsigned sec, stk;
      for (int n = 0; n < count; n++) begin
         if (n % 125 == 0) begin
            drain();
            case ($urandom_range(4))
               0: write_reg(CSR_RADIUS, $urandom_range(0, 65535));
               1: write_reg(CSR_RADIUS, 256);
               default: write_reg(CSR_RADIUS, $urandom_range(1, 4096));
            endcase
            write_reg(CSR_SECTORS, ($urandom_range(9) == 0) ?
                      $urandom_range(0, 511) : $urandom_range(3, 40));
            write_reg(CSR_STACKS, ($urandom_range(9) == 0) ?
                      $urandom_range(0, 511) : $urandom_range(2, 40));
            steady = (n == 500);
         end
         sec = div_clamp(sectors_raw, 3);
         stk = div_clamp(stacks_raw, 2);
         if ($urandom_range(9) == 0)
            send_point($urandom_range(0, 511), $urandom_range(0, 511));
         else
            send_point($urandom_range(0, stk + 1), $urandom_range(0, sec + 1));
      end
      steady = 1'b0;
      drain();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_defaults();
      test_grid_edges();
      test_random(1250);
      if (expected_vertices.size() != 0) mismatches++;
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
